### hw/rtl/wsfd_pkg.sv
// ----------------------------------------------------------------------------
// wsfd_pkg
// Types and constants shared by the WebSocket frame decoder modules.
// ----------------------------------------------------------------------------
package wsfd_pkg;

	localparam int BYTE_W  = 8;
	localparam int LEN_W   = 64;
	localparam int TDATA_W = 152;

	// output tdata field positions
	localparam int FIN_LSB    = 0;
	localparam int RSV_LSB    = 1;
	localparam int OPCODE_LSB = 4;
	localparam int MASKED_LSB = 8;
	localparam int LEN_LSB    = 9;
	localparam int DATA_LSB   = 73;
	localparam int OFFSET_LSB = 81;

	localparam logic [6:0] LEN_CODE_16 = 7'd126;
	localparam logic [6:0] LEN_CODE_64 = 7'd127;
	localparam logic [2:0] EXT_CNT_16  = 3'd1;
	localparam logic [2:0] EXT_CNT_64  = 3'd7;
	localparam logic [1:0] MASK_LAST   = 2'd3;

	typedef enum logic [2:0] {
		PH_HDR0    = 3'd0,
		PH_HDR1    = 3'd1,
		PH_EXTLEN  = 3'd2,
		PH_MASK    = 3'd3,
		PH_PAYLOAD = 3'd4
	} phase_t;

	typedef enum logic {
		KIND_HEADER  = 1'b0,
		KIND_PAYLOAD = 1'b1
	} kind_t;

	typedef struct packed {
		kind_t              kind;
		logic               fin;
		logic [2:0]         rsv;
		logic [3:0]         opcode;
		logic               masked;
		logic [LEN_W-1:0]   length;
		logic [BYTE_W-1:0]  data;
		logic [BYTE_W-1:0]  key;
		logic [LEN_W-1:0]   offset;
		logic               done;
	} entry_t;

	typedef struct packed {
		logic full;
		logic valid;
	} q_status_t;

endpackage

### hw/rtl/wsfd_front.sv
// ----------------------------------------------------------------------------
// wsfd_front
// Header parser: accepts stream bytes, tracks frame state and issues one
// queue entry per header event or payload byte.
// ----------------------------------------------------------------------------
module wsfd_front (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	input  logic [7:0]             in_byte,
	input  wsfd_pkg::q_status_t    q_status,
	output logic                   in_ready,
	output logic                   push,
	output wsfd_pkg::entry_t       entry
);
	import wsfd_pkg::*;

	phase_t            phase_q, phase_d;
	logic [2:0]        ext_cnt_q, ext_cnt_d;
	logic [1:0]        mask_cnt_q, mask_cnt_d;
	logic              fin_q, fin_d;
	logic [2:0]        rsv_q, rsv_d;
	logic [3:0]        opcode_q, opcode_d;
	logic              masked_q, masked_d;
	logic [LEN_W-1:0]  len_q, len_d;
	logic [BYTE_W-1:0] key_q [4];
	logic [LEN_W-1:0]  pcnt_q, pcnt_d;
	logic [LEN_W-1:0]  pcnt_inc;
	logic              key_we;
	logic              accept;
	logic              emit_hdr;
	logic              emit_pay;
	logic              after_len;

	assign in_ready = !q_status.full;
	assign accept   = in_valid && in_ready;
	assign pcnt_inc = pcnt_q + LEN_W'(1);

	always_comb begin
		phase_d    = phase_q;
		ext_cnt_d  = ext_cnt_q;
		mask_cnt_d = mask_cnt_q;
		fin_d      = fin_q;
		rsv_d      = rsv_q;
		opcode_d   = opcode_q;
		masked_d   = masked_q;
		len_d      = len_q;
		pcnt_d     = pcnt_q;
		key_we     = 1'b0;
		emit_hdr   = 1'b0;
		emit_pay   = 1'b0;
		after_len  = 1'b0;
		unique case (phase_q)
			PH_HDR0: begin
				fin_d    = in_byte[7];
				rsv_d    = in_byte[6:4];
				opcode_d = in_byte[3:0];
				phase_d  = PH_HDR1;
			end
			PH_HDR1: begin
				masked_d = in_byte[7];
				if (in_byte[6:0] == LEN_CODE_16 || in_byte[6:0] == LEN_CODE_64) begin
					len_d     = '0;
					ext_cnt_d = (in_byte[6:0] == LEN_CODE_16) ? EXT_CNT_16 : EXT_CNT_64;
					phase_d   = PH_EXTLEN;
				end else begin
					len_d     = LEN_W'(in_byte[6:0]);
					after_len = 1'b1;
				end
			end
			PH_EXTLEN: begin
				len_d = {len_q[LEN_W-BYTE_W-1:0], in_byte};
				if (ext_cnt_q == '0) begin
					after_len = 1'b1;
				end else begin
					ext_cnt_d = ext_cnt_q - 3'd1;
				end
			end
			PH_MASK: begin
				key_we = 1'b1;
				if (mask_cnt_q == MASK_LAST) begin
					mask_cnt_d = '0;
					emit_hdr   = 1'b1;
				end else begin
					mask_cnt_d = mask_cnt_q + 2'd1;
				end
			end
			PH_PAYLOAD: begin
				emit_pay = 1'b1;
				pcnt_d   = pcnt_inc;
				if (pcnt_inc == len_q) begin
					phase_d = PH_HDR0;
				end
			end
			default: begin
				phase_d = PH_HDR0;
			end
		endcase
		if (after_len) begin
			if (masked_d) begin
				mask_cnt_d = '0;
				phase_d    = PH_MASK;
			end else begin
				emit_hdr = 1'b1;
			end
		end
		if (emit_hdr) begin
			pcnt_d  = '0;
			phase_d = (len_d == '0) ? PH_HDR0 : PH_PAYLOAD;
		end
	end

	always_comb begin
		entry.kind   = emit_pay ? KIND_PAYLOAD : KIND_HEADER;
		entry.fin    = fin_d;
		entry.rsv    = rsv_d;
		entry.opcode = opcode_d;
		entry.masked = masked_d;
		entry.length = len_d;
		entry.data   = emit_pay ? in_byte : '0;
		entry.key    = (emit_pay && masked_q) ? key_q[pcnt_q[1:0]] : '0;
		entry.offset = emit_pay ? pcnt_q : '0;
		entry.done   = emit_pay ? (pcnt_inc == len_q) : (len_d == '0);
	end

	assign push = accept && (emit_hdr || emit_pay);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_HDR0;
			ext_cnt_q  <= '0;
			mask_cnt_q <= '0;
			fin_q      <= 1'b0;
			rsv_q      <= '0;
			opcode_q   <= '0;
			masked_q   <= 1'b0;
			len_q      <= '0;
			pcnt_q     <= '0;
			for (int i = 0; i < 4; i++) begin
				key_q[i] <= '0;
			end
		end else if (accept) begin
			phase_q    <= phase_d;
			ext_cnt_q  <= ext_cnt_d;
			mask_cnt_q <= mask_cnt_d;
			fin_q      <= fin_d;
			rsv_q      <= rsv_d;
			opcode_q   <= opcode_d;
			masked_q   <= masked_d;
			len_q      <= len_d;
			pcnt_q     <= pcnt_d;
			if (key_we) begin
				key_q[mask_cnt_q] <= in_byte;
			end
		end
	end

endmodule

### hw/rtl/wsfd_queue.sv
// ----------------------------------------------------------------------------
// wsfd_queue
// Two-entry queue between parser and output stage.
// ----------------------------------------------------------------------------
module wsfd_queue (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  wsfd_pkg::entry_t       wr_entry,
	input  logic                   pop,
	output wsfd_pkg::q_status_t    status,
	output wsfd_pkg::entry_t       rd_entry
);
	import wsfd_pkg::*;

	entry_t     mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       do_push;
	logic       do_pop;

	assign status.full  = (count_q == 2'd2);
	assign status.valid = (count_q != 2'd0);
	assign do_push      = push && !status.full;
	assign do_pop       = pop && status.valid;
	assign rd_entry     = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

### hw/rtl/wsfd_back.sv
// ----------------------------------------------------------------------------
// wsfd_back
// Output stage: unmasks payload bytes and holds the result item register.
// ----------------------------------------------------------------------------
module wsfd_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  wsfd_pkg::q_status_t        q_status,
	input  wsfd_pkg::entry_t           q_entry,
	output logic                       pop,
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [wsfd_pkg::TDATA_W-1:0] m_tdata,
	output logic                       m_tuser,
	output logic                       m_tlast
);
	import wsfd_pkg::*;

	logic load;

	assign load = q_status.valid && (!m_tvalid || m_tready);
	assign pop  = load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (!m_tvalid || m_tready) begin
			m_tvalid <= q_status.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			m_tdata <= {
				7'd0,
				q_entry.offset,
				q_entry.data ^ q_entry.key,
				q_entry.length,
				q_entry.masked,
				q_entry.opcode,
				q_entry.rsv,
				q_entry.fin
			};
			m_tuser <= q_entry.kind;
			m_tlast <= q_entry.done;
		end
	end

endmodule

### hw/rtl/websocket_frame_decoder_top.sv
// ----------------------------------------------------------------------------
// websocket_frame_decoder_top
// Path: a result item is written to a queue entry at the edge that accepts
// the byte causing it, then loaded into the output register (m_ ports).
// Throughput: one byte per cycle; s_tready drops only when the two-entry
// queue is full while m_tready is held low.
// Reset: arst_n clears parser state and empties queue and output register.
// ----------------------------------------------------------------------------
module websocket_frame_decoder_top (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [7:0]                  s_tdata,   // rx_byte[7:0]
	output logic                        m_tvalid,
	input  logic                        m_tready,
	// fin, rsv[3], opcode[4], masked, payload_length[64], data_out[8],
	// byte_offset[64], zero fill
	output logic [wsfd_pkg::TDATA_W-1:0] m_tdata,
	output logic                        m_tuser,   // kind
	output logic                        m_tlast    // frame_done
);
	import wsfd_pkg::*;

	q_status_t q_status;
	entry_t    wr_entry;
	entry_t    rd_entry;
	logic      push;
	logic      pop;

	wsfd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_byte  (s_tdata),
		.q_status (q_status),
		.in_ready (s_tready),
		.push     (push),
		.entry    (wr_entry)
	);

	wsfd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_entry (wr_entry),
		.pop      (pop),
		.status   (q_status),
		.rd_entry (rd_entry)
	);

	wsfd_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_status (q_status),
		.q_entry  (rd_entry),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

### hw/rtl/wsfd_checker.sv
// ----------------------------------------------------------------------------
// wsfd_checker
// Port-level checks on the decoder's result stream.
// ----------------------------------------------------------------------------
module wsfd_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        m_tvalid,
	input logic                        m_tready,
	input logic [wsfd_pkg::TDATA_W-1:0] m_tdata,
	input logic                        m_tuser,
	input logic                        m_tlast
);
	import wsfd_pkg::*;

	logic [LEN_W-1:0]  len_w;
	logic [LEN_W-1:0]  off_w;
	logic [BYTE_W-1:0] data_w;

	assign len_w  = m_tdata[LEN_LSB +: LEN_W];
	assign off_w  = m_tdata[OFFSET_LSB +: LEN_W];
	assign data_w = m_tdata[DATA_LSB +: BYTE_W];

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("result item changed while stalled");

	a_hdr_done: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == KIND_HEADER) |-> (m_tlast == (len_w == '0)))
		else $error("header done flag disagrees with length");

	a_hdr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == KIND_HEADER) |-> (data_w == '0) && (off_w == '0))
		else $error("header item carries data or offset");

	a_pay_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == KIND_PAYLOAD) |->
			(m_tlast == (LEN_W'(off_w + LEN_W'(1)) == len_w)))
		else $error("payload done flag disagrees with offset");

endmodule

bind websocket_frame_decoder_top wsfd_checker u_wsfd_checker (.*);
